// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the ring buffer RTL.
// Users include this header by its bare name; the macros expect i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

// ===== rtl/itrb_pkg.sv =====
// Shared types, constants and helper function for the integrating timeline ring buffer.
// No dependencies; every RTL module refers to it by scoped names.
package itrb_pkg;

    localparam int DEPTH      = 64;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int LEN_W      = 7;
    localparam int STAMP_W    = 32;
    localparam int VALUE_W    = 48;
    localparam int RATE_W     = 32;
    localparam int IDX_W      = 7;
    localparam int STATE_W    = 8;
    localparam int FUNC_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 120;
    localparam int IN_USER_W  = 3;
    localparam int OUT_USER_W = 3;

    // Operation codes carried in the input tuser.
    localparam logic [FUNC_W-1:0] FUNC_RES_APPEND   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_STATE_APPEND = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_DEQUEUE      = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_PEEK         = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR        = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VALUE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_RATE  = 2'd2;

    localparam logic [LEN_W-1:0] ACTIVE_LENGTH_RESET = 7'd64;
    localparam logic [LEN_W-1:0] LEN_MIN = 7'd2;

    localparam logic signed [63:0] VALUE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] VALUE_MIN = 64'shFFFF_8000_0000_0000;
    localparam logic signed [RATE_W-1:0] RATE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [RATE_W-1:0] RATE_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [STAMP_W-1:0]        stamp;
        logic signed [VALUE_W-1:0] value;
        logic signed [RATE_W-1:0]  rate;
    } t_entry;

    typedef struct packed {
        logic             re;
        logic [PTR_W-1:0] raddr;
        logic             we;
        logic [PTR_W-1:0] waddr;
        t_entry           wdata;
    } t_mem_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_SCALE,
        S_FINISH
    } t_state;

    // Quotient digit of n / 15 for n below 240: 17/256 approximates 1/15 from
    // below by less than one, so a single correction step suffices.
    function automatic logic [3:0] div15_digit(input logic [7:0] n);
        logic [11:0] p;
        logic [3:0]  q;
        logic [7:0]  r;
        p = 12'(n) * 12'd17;
        q = p[11:8];
        r = n - 8'(q) * 8'd15;
        if (r >= 8'd15) begin
            q = q + 4'd1;
        end
        return q;
    endfunction

endpackage

// ===== rtl/itrb_mem.sv =====
// Entry store of the ring: one write port and one registered read port.
// Depends on itrb_pkg; entry zero reads as all zeros until it is first written.
module itrb_mem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  itrb_pkg::t_mem_req i_req,
    output itrb_pkg::t_entry   o_rdata
);

    itrb_pkg::t_entry r_mem [itrb_pkg::DEPTH];
    itrb_pkg::t_entry r_rdata;
    logic             r_base_ok;
    logic             r_rd_blank;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    // The base entry has a defined reset value; the others do not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_ok  <= 1'b0;
            r_rd_blank <= 1'b0;
        end else begin
            if (i_req.we && (i_req.waddr == '0)) begin
                r_base_ok <= 1'b1;
            end
            if (i_req.re) begin
                r_rd_blank <= (i_req.raddr == '0) && !r_base_ok;
            end
        end
    end

    assign o_rdata = r_rd_blank ? '0 : r_rdata;

endmodule

// ===== rtl/itrb_scale.sv =====
// Shared arithmetic unit: elapsed time times rate, divided by 60 toward zero.
// Depends on itrb_pkg and assert_macros.svh; a multiply, then 16 radix-16 steps.
`include "assert_macros.svh"

module itrb_scale (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [32:0] i_dt,
    input  logic signed [31:0] i_rate,
    output logic               o_done,
    output logic signed [63:0] o_term
);

    logic        r_busy;
    logic        r_mul;
    logic        r_done;
    logic [3:0]  r_cnt;
    logic        r_neg;
    logic [31:0] r_a;
    logic [31:0] r_b;
    logic [63:0] r_num;
    logic [3:0]  r_rem;

    logic [63:0] w_prod;
    logic [7:0]  w_part;
    logic [3:0]  w_qd;
    logic [7:0]  w_rem;

    assign w_prod = r_a * r_b;

    // Each step brings down the next dividend nibble and shifts in one
    // quotient digit, so r_num ends up holding the quotient.
    assign w_part = {r_rem, r_num[63:60]};
    assign w_qd   = itrb_pkg::div15_digit(w_part);
    assign w_rem  = w_part - 8'(w_qd) * 8'd15;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mul  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_mul  <= 1'b1;
            end else if (r_busy && r_mul) begin
                r_mul <= 1'b0;
                r_cnt <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'hF) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_dt[32] ? 32'(-i_dt) : i_dt[31:0];
            r_b   <= i_rate[31] ? 32'(-i_rate) : i_rate;
            r_neg <= i_dt[32] ^ i_rate[31];
        end else if (r_busy && r_mul) begin
            // Dividing by 4 here leaves a division by 15 for the digit steps.
            r_num <= {2'b00, w_prod[63:2]};
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[59:0], w_qd};
            r_rem <= w_rem[3:0];
        end
    end

    assign o_done = r_done;
    assign o_term = r_neg ? -$signed(r_num) : $signed(r_num);

    `ASSERT_CLK(a_start_idle, i_start |-> !r_busy, "scale unit started while busy")
    `ASSERT_CLK(a_done_pulse, r_done |=> !r_done, "scale done held for more than one cycle")
    `ASSERT_ANY(a_done_not_busy, r_done |-> !r_busy, "scale done while still busy")

endmodule

// ===== rtl/integrating_timeline_ring_buffer_core.sv =====
// Integrating timeline ring buffer, top level. Depends on itrb_pkg, itrb_mem,
// itrb_scale and assert_macros.svh.
// Input beats on s_axis carry one operation: tuser holds the operation code,
// tdata the event time, value step, rate step and state number. Each beat
// produces exactly one result beat on m_axis: tdata holds the entry's stamp,
// value, rate and the append index, tuser the appended flag and the status.
// Registers are written on the cfg channel, which is always ready; write only
// while no operation is in flight.
// Flow: s_axis_tready is high only while the sequencer is idle. A resource
// append runs from acceptance to the result register through an entry read,
// one 32x32 multiply, 16 radix-16 divide-by-15 steps, integration and
// write-back; every other operation runs through read, decode and write-back.
// The result register lets the next beat be accepted while a result waits;
// if m_axis stays stalled, the following operation holds at its last step.
// Reset clears the pointers, the result valid and the registers to their
// defaults; the base entry reads as zero until it is first written.
`include "assert_macros.svh"

module integrating_timeline_ring_buffer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // time_stamp[31:0], value_change[79:32], rate_change[111:80], new_state[119:112]
    input  logic [itrb_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // func[2:0]
    input  logic [itrb_pkg::IN_USER_W-1:0]      i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // out_stamp[31:0], out_value[79:32], out_rate[111:80], entry_index[118:112], zero[119]
    output logic [itrb_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // appended[0], status[2:1]
    output logic [itrb_pkg::OUT_USER_W-1:0]     o_m_axis_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [itrb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [itrb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    itrb_pkg::t_state r_state;
    itrb_pkg::t_state n_state;

    logic [itrb_pkg::PTR_W-1:0]          r_h;
    logic [itrb_pkg::PTR_W-1:0]          r_t;
    logic [itrb_pkg::LEN_W-1:0]          r_active_length;
    logic signed [itrb_pkg::VALUE_W-1:0] r_init_value;
    logic signed [itrb_pkg::RATE_W-1:0]  r_init_rate;

    logic [itrb_pkg::FUNC_W-1:0]         r_func;
    logic [itrb_pkg::STAMP_W-1:0]        r_ts;
    logic signed [itrb_pkg::VALUE_W-1:0] r_dv;
    logic signed [itrb_pkg::RATE_W-1:0]  r_dr;
    logic [itrb_pkg::STATE_W-1:0]        r_ns;

    logic                                r_out_valid;
    itrb_pkg::t_entry                    r_out_entry;
    logic [itrb_pkg::IDX_W-1:0]          r_out_idx;
    logic                                r_out_app;
    logic [itrb_pkg::STATUS_W-1:0]       r_out_status;

    logic                                w_in_acc;
    logic [itrb_pkg::FUNC_W-1:0]         w_in_func;
    logic                                w_out_free;
    logic                                w_finish_go;
    logic                                w_scale_start;
    logic                                w_scale_done;
    logic signed [63:0]                  w_term;
    logic signed [32:0]                  w_dt;
    itrb_pkg::t_mem_req                  w_mem_req;
    itrb_pkg::t_entry                    w_entry;

    logic [itrb_pkg::LEN_W-1:0]          w_len;
    logic [itrb_pkg::IDX_W-1:0]          w_idx;
    logic [itrb_pkg::PTR_W-1:0]          w_h_nx;
    logic [itrb_pkg::IDX_W-1:0]          w_t_inc;
    logic [itrb_pkg::PTR_W-1:0]          w_t_nx;
    logic signed [63:0]                  w_vsum;
    logic signed [32:0]                  w_rsum;
    logic                                w_vsat;
    logic                                w_rsat;
    logic signed [32:0]                  w_hstate;
    logic                                w_same_state;
    itrb_pkg::t_entry                    w_cand;

    itrb_pkg::t_entry                    w_res_entry;
    logic [itrb_pkg::IDX_W-1:0]          w_res_idx;
    logic                                w_res_app;
    logic [itrb_pkg::STATUS_W-1:0]       w_res_status;
    logic [itrb_pkg::PTR_W-1:0]          w_res_h;
    logic [itrb_pkg::PTR_W-1:0]          w_res_t;
    logic                                w_res_we;
    logic [itrb_pkg::PTR_W-1:0]          w_res_waddr;
    itrb_pkg::t_entry                    w_res_wdata;

    assign w_in_func  = i_s_axis_tuser;
    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    itrb_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mem_req),
        .o_rdata (w_entry)
    );

    assign w_dt = $signed({1'b0, r_ts}) - $signed({1'b0, w_entry.stamp});

    itrb_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_scale_start),
        .i_dt    (w_dt),
        .i_rate  (w_entry.rate),
        .o_done  (w_scale_done),
        .o_term  (w_term)
    );

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itrb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            itrb_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = itrb_pkg::S_LOAD;
                end
            end
            itrb_pkg::S_LOAD: begin
                if (r_func == itrb_pkg::FUNC_RES_APPEND) begin
                    n_state = itrb_pkg::S_SCALE;
                end else begin
                    n_state = itrb_pkg::S_FINISH;
                end
            end
            itrb_pkg::S_SCALE: begin
                if (w_scale_done) begin
                    n_state = itrb_pkg::S_FINISH;
                end
            end
            itrb_pkg::S_FINISH: begin
                if (w_out_free) begin
                    n_state = itrb_pkg::S_IDLE;
                end
            end
            default: n_state = itrb_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == itrb_pkg::S_IDLE);
        w_scale_start   = (r_state == itrb_pkg::S_LOAD)
                          && (r_func == itrb_pkg::FUNC_RES_APPEND);
        w_finish_go     = (r_state == itrb_pkg::S_FINISH) && w_out_free;

        w_mem_req.re    = w_in_acc;
        w_mem_req.raddr = (w_in_func inside {itrb_pkg::FUNC_RES_APPEND,
                                             itrb_pkg::FUNC_STATE_APPEND}) ? r_h : r_t;
        w_mem_req.we    = w_finish_go && w_res_we;
        w_mem_req.waddr = w_res_waddr;
        w_mem_req.wdata = w_res_wdata;
    end

    // ---------------------------------------------------------------- datapath
    always_comb begin
        if (r_active_length < itrb_pkg::LEN_MIN) begin
            w_len = itrb_pkg::LEN_MIN;
        end else if (r_active_length > itrb_pkg::LEN_W'(itrb_pkg::DEPTH)) begin
            w_len = itrb_pkg::LEN_W'(itrb_pkg::DEPTH);
        end else begin
            w_len = r_active_length;
        end
    end

    assign w_idx   = itrb_pkg::IDX_W'(r_h) + itrb_pkg::IDX_W'(1);
    assign w_h_nx  = (w_idx >= w_len) ? '0 : w_idx[itrb_pkg::PTR_W-1:0];
    assign w_t_inc = itrb_pkg::IDX_W'(r_t) + itrb_pkg::IDX_W'(1);
    assign w_t_nx  = (w_t_inc >= w_len) ? '0 : w_t_inc[itrb_pkg::PTR_W-1:0];

    assign w_vsum = $signed({{16{r_dv[47]}}, r_dv})
                    + $signed({{16{w_entry.value[47]}}, w_entry.value})
                    + w_term;
    assign w_vsat = (w_vsum > itrb_pkg::VALUE_MAX) || (w_vsum < itrb_pkg::VALUE_MIN);
    assign w_rsum = $signed({w_entry.rate[31], w_entry.rate}) + $signed({r_dr[31], r_dr});
    assign w_rsat = (w_rsum[32] != w_rsum[31]);

    // Head value truncated toward zero to a whole state number.
    assign w_hstate = $signed({w_entry.value[47], w_entry.value[47:16]})
                      + $signed({32'd0, w_entry.value[47] && (w_entry.value[15:0] != '0)});
    assign w_same_state = (w_hstate == $signed({25'd0, r_ns}));

    always_comb begin
        w_cand.stamp = r_ts;
        if (r_func == itrb_pkg::FUNC_RES_APPEND) begin
            if (w_vsum > itrb_pkg::VALUE_MAX) begin
                w_cand.value = itrb_pkg::VALUE_MAX[47:0];
            end else if (w_vsum < itrb_pkg::VALUE_MIN) begin
                w_cand.value = itrb_pkg::VALUE_MIN[47:0];
            end else begin
                w_cand.value = w_vsum[47:0];
            end
            if (w_rsat) begin
                w_cand.rate = w_rsum[32] ? itrb_pkg::RATE_MIN : itrb_pkg::RATE_MAX;
            end else begin
                w_cand.rate = w_rsum[31:0];
            end
        end else begin
            w_cand.value = {24'd0, r_ns, 16'd0};
            w_cand.rate  = '0;
        end
    end

    always_comb begin
        w_res_entry  = '0;
        w_res_idx    = '0;
        w_res_app    = 1'b0;
        w_res_status = itrb_pkg::STATUS_OK;
        w_res_h      = r_h;
        w_res_t      = r_t;
        w_res_we     = 1'b0;
        w_res_waddr  = w_h_nx;
        w_res_wdata  = w_cand;
        case (r_func)
            itrb_pkg::FUNC_RES_APPEND, itrb_pkg::FUNC_STATE_APPEND: begin
                w_res_idx = w_idx;
                if ((r_func == itrb_pkg::FUNC_STATE_APPEND) && w_same_state) begin
                    w_res_entry = w_entry;
                end else if (w_h_nx == r_t) begin
                    w_res_entry  = w_cand;
                    w_res_status = itrb_pkg::STATUS_FULL;
                end else begin
                    w_res_entry = w_cand;
                    w_res_app   = 1'b1;
                    w_res_we    = 1'b1;
                    w_res_h     = w_h_nx;
                    if ((r_func == itrb_pkg::FUNC_RES_APPEND) && (w_vsat || w_rsat)) begin
                        w_res_status = itrb_pkg::STATUS_SAT;
                    end
                end
            end
            itrb_pkg::FUNC_DEQUEUE: begin
                w_res_entry = w_entry;
                if (r_h == r_t) begin
                    w_res_status = itrb_pkg::STATUS_EMPTY;
                end else begin
                    w_res_we    = 1'b1;
                    w_res_waddr = r_t;
                    w_res_wdata = '0;
                    w_res_t     = w_t_nx;
                end
            end
            itrb_pkg::FUNC_PEEK: begin
                w_res_entry = w_entry;
            end
            itrb_pkg::FUNC_CLEAR: begin
                w_res_entry.stamp = '0;
                w_res_entry.value = r_init_value;
                w_res_entry.rate  = r_init_rate;
                w_res_we          = 1'b1;
                w_res_waddr       = r_h;
                w_res_wdata       = w_res_entry;
                w_res_t           = r_h;
            end
            default: begin
                w_res_entry = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_func <= w_in_func;
            r_ts   <= i_s_axis_tdata[31:0];
            r_dv   <= i_s_axis_tdata[79:32];
            r_dr   <= i_s_axis_tdata[111:80];
            r_ns   <= i_s_axis_tdata[119:112];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h         <= '0;
            r_t         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_finish_go) begin
                r_h         <= w_res_h;
                r_t         <= w_res_t;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish_go) begin
            r_out_entry  <= w_res_entry;
            r_out_idx    <= w_res_idx;
            r_out_app    <= w_res_app;
            r_out_status <= w_res_status;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_length <= itrb_pkg::ACTIVE_LENGTH_RESET;
            r_init_value    <= '0;
            r_init_rate     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                itrb_pkg::CFG_ACTIVE_LENGTH: r_active_length <= i_cfg_data[6:0];
                itrb_pkg::CFG_INITIAL_VALUE: r_init_value    <= i_cfg_data[47:0];
                itrb_pkg::CFG_INITIAL_RATE:  r_init_rate     <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_idx, r_out_entry.rate, r_out_entry.value,
                              r_out_entry.stamp};
    assign o_m_axis_tuser  = {r_out_status, r_out_app};

    `ASSERT_CLK(a_out_from_finish, $rose(r_out_valid) |-> $past(r_state == itrb_pkg::S_FINISH), "result loaded outside the final step")
    `ASSERT_CLK(a_head_move, $past(i_rst_n) && (r_h != $past(r_h)) |-> $past(r_state == itrb_pkg::S_FINISH), "head pointer moved outside the final step")
    `ASSERT_CLK(a_tail_move, $past(i_rst_n) && (r_t != $past(r_t)) |-> $past(r_state == itrb_pkg::S_FINISH), "tail pointer moved outside the final step")

endmodule
